/* rtl/dci_pkg.sv */
// ----------------------------------------------------------------------------
// dci_pkg: shared types and constants for the dsp core interrupt controller
// Command and register codes, request and response records, default sizes.
// ----------------------------------------------------------------------------
package dci_pkg;

  localparam int DEF_EVENT_GROUPS = 4;
  localparam int DEF_DSP_INTS     = 12;

  localparam int MAX_GROUPS = 4;
  localparam int MAX_INTS   = 12;
  localparam int WORD_W     = 32;
  localparam int EVT_W      = 7;
  localparam int ADDR_W     = 5;
  localparam int SELF_W     = 4;
  localparam int FIELDS_PER_REG = 4;
  localparam int FIELD_STRIDE   = 8;

  localparam logic [ADDR_W-1:0] ADDR_LAST = 5'd22;

  typedef enum logic [1:0] {
    CMD_PULSE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_BAD   = 2'd3
  } dci_cmd_e;

  typedef enum logic [2:0] {
    KIND_FLAG  = 3'd0,
    KIND_SET   = 3'd1,
    KIND_CLR   = 3'd2,
    KIND_MASK  = 3'd3,
    KIND_MFLAG = 3'd4,
    KIND_MUX   = 3'd5
  } dci_kind_e;

  typedef struct packed {
    dci_cmd_e          cmd;
    logic [ADDR_W-1:0] reg_addr;
    logic [WORD_W-1:0] wdata;
    logic [EVT_W-1:0]  event_num;
  } dci_req_t;

  typedef struct packed {
    logic [SELF_W-1:0]   combined_events;
    logic [MAX_INTS-1:0] dsp_int_lines;
    logic                status;
    logic [WORD_W-1:0]   rdata;
  } dci_rsp_t;

endpackage

/* rtl/dci_regs.sv */
// ----------------------------------------------------------------------------
// dci_regs: flag, mask and mux register file
// Decodes one request, updates the state and forms the response from the
// state as it stands after the update.
// ----------------------------------------------------------------------------
module dci_regs
  import dci_pkg::*;
#(
  parameter int EVENT_GROUPS = DEF_EVENT_GROUPS,
  parameter int DSP_INTS     = DEF_DSP_INTS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  dci_req_t req,
  output dci_rsp_t rsp
);

  logic [WORD_W-1:0] flags      [EVENT_GROUPS];
  logic [WORD_W-1:0] flags_next [EVENT_GROUPS];
  logic [WORD_W-1:0] masks      [EVENT_GROUPS];
  logic [WORD_W-1:0] masks_next [EVENT_GROUPS];
  logic [EVT_W-1:0]  sel        [DSP_INTS];
  logic [EVT_W-1:0]  sel_next   [DSP_INTS];

  dci_kind_e         kind;
  logic [1:0]        grp;
  logic              grp_ok;
  logic [WORD_W-1:0] rdata;
  logic              status;
  logic [MAX_INTS-1:0] lines;
  logic [SELF_W-1:0]   comb;

  assign kind = dci_kind_e'(req.reg_addr[4:2]);
  assign grp  = req.reg_addr[1:0];

  always_comb begin
    for (int k = 0; k < EVENT_GROUPS; k++) begin
      flags_next[k] = flags[k];
      masks_next[k] = masks[k];
    end
    for (int j = 0; j < DSP_INTS; j++) begin
      sel_next[j] = sel[j];
    end
    rdata  = '0;
    status = 1'b0;
    grp_ok = 1'b0;
    for (int k = 0; k < EVENT_GROUPS; k++) begin
      if (grp == 2'(k)) grp_ok = 1'b1;
    end

    case (req.cmd)
      CMD_PULSE: begin
        for (int k = 0; k < EVENT_GROUPS; k++) begin
          if (req.event_num[6:5] == 2'(k)) flags_next[k][req.event_num[4:0]] = 1'b1;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (req.reg_addr > ADDR_LAST) begin
          status = 1'b1;
        end else if (kind == KIND_MUX) begin
          // mux register grp holds selectors 4*grp .. 4*grp+3, one per byte
          for (int j = 0; j < DSP_INTS; j++) begin
            if (grp == 2'(j / FIELDS_PER_REG)) begin
              if (req.cmd == CMD_READ) begin
                rdata[FIELD_STRIDE*(j%FIELDS_PER_REG) +: EVT_W] = sel[j];
              end else begin
                sel_next[j] = req.wdata[FIELD_STRIDE*(j%FIELDS_PER_REG) +: EVT_W];
              end
            end
          end
        end else if (!grp_ok) begin
          status = 1'b1;
        end else begin
          for (int k = 0; k < EVENT_GROUPS; k++) begin
            if (grp == 2'(k)) begin
              if (req.cmd == CMD_READ) begin
                case (kind)
                  KIND_FLAG:  rdata = flags[k];
                  KIND_MASK:  rdata = masks[k];
                  KIND_MFLAG: rdata = flags[k] & ~masks[k];
                  default:    rdata = '0;
                endcase
              end else begin
                case (kind)
                  KIND_SET: flags_next[k] = flags[k] | req.wdata;
                  KIND_CLR: flags_next[k] = flags[k] & ~req.wdata;
                  KIND_MASK: begin
                    masks_next[k] = req.wdata;
                    // events 0-3 never feed their own combiner
                    if (k == 0) masks_next[k][SELF_W-1:0] = '1;
                  end
                  default: status = 1'b1;
                endcase
              end
            end
          end
        end
      end
      default: status = 1'b1;
    endcase
  end

  always_comb begin
    lines = '0;
    comb  = '0;
    for (int j = 0; j < DSP_INTS; j++) begin
      for (int k = 0; k < EVENT_GROUPS; k++) begin
        if (sel_next[j][6:5] == 2'(k)) lines[j] = flags_next[k][sel_next[j][4:0]];
      end
    end
    for (int k = 0; k < EVENT_GROUPS; k++) begin
      comb[k] = |(flags_next[k] & ~masks_next[k]);
    end
  end

  assign rsp.rdata           = rdata;
  assign rsp.status          = status;
  assign rsp.dsp_int_lines   = lines;
  assign rsp.combined_events = comb;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < EVENT_GROUPS; k++) begin
        flags[k] <= '0;
        masks[k] <= '1;
      end
      for (int j = 0; j < DSP_INTS; j++) begin
        sel[j] <= '0;
      end
    end else if (step) begin
      for (int k = 0; k < EVENT_GROUPS; k++) begin
        flags[k] <= flags_next[k];
        masks[k] <= masks_next[k];
      end
      for (int j = 0; j < DSP_INTS; j++) begin
        sel[j] <= sel_next[j];
      end
    end
  end

  a_self_mask: assert property (@(posedge clk) disable iff (rst)
    masks[0][SELF_W-1:0] == '1)
    else $error("self-combine mask bits of group 0 cleared");

endmodule

/* rtl/dsp_core_interrupt_controller.sv */
// ----------------------------------------------------------------------------
// dsp_core_interrupt_controller: event flags, combiner and interrupt mux
// Takes bus reads, bus writes and system event pulses on one stream and
// returns one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ group: s_tuser carries the command (pulse, read,
//   write), s_tdata the register address, write data and event number.
//   Each request yields exactly one response on the m_ group: read data and
//   the mapped interrupt lines and combined events after the update in
//   m_tdata, the error flag in m_tuser.
//   A request passes from acceptance through one input register, then a
//   single decode and update pass into the response register that drives m_tvalid.
//   One request is taken every cycle while the receiver keeps up; the
//   register file updates in the same pass, so back-to-back requests see
//   each other's effects in order.
//   When m_tready is low the response register holds and one more request
//   can wait in the input register; after that s_tready drops.
//   Synchronous reset clears all flags and mux selectors, masks every event
//   and empties both registers.
// ----------------------------------------------------------------------------
module dsp_core_interrupt_controller
  import dci_pkg::*;
#(
  parameter int EVENT_GROUPS = DEF_EVENT_GROUPS,
  parameter int DSP_INTS     = DEF_DSP_INTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // reg_addr[4:0], wdata[36:5], event_num[43:37], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // rdata[31:0], dsp_int_lines[43:32], combined_events[47:44]
  output logic        m_tuser    // status[0]
);

  logic     in_valid;
  dci_req_t in_req;
  logic     out_valid;
  dci_rsp_t out_rsp;
  dci_rsp_t rsp;
  logic     advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.cmd       <= dci_cmd_e'(s_tuser);
      in_req.reg_addr  <= s_tdata[4:0];
      in_req.wdata     <= s_tdata[36:5];
      in_req.event_num <= s_tdata[43:37];
    end
  end

  dci_regs #(
    .EVENT_GROUPS (EVENT_GROUPS),
    .DSP_INTS     (DSP_INTS)
  ) u_regs (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (in_req),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_rsp <= rsp;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_rsp.combined_events, out_rsp.dsp_int_lines, out_rsp.rdata};
  assign m_tuser  = out_rsp.status;

  a_bad_cmd: assert property (@(posedge clk) disable iff (rst)
    advance && in_req.cmd == CMD_BAD |=> m_tuser && m_tdata[31:0] == '0)
    else $error("bad command not flagged");

  a_pulse_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && in_req.cmd == CMD_PULSE |=> !m_tuser && m_tdata[31:0] == '0)
    else $error("event pulse returned data or error");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled without a full pipeline");

endmodule
